// ===== hdl/sbod_pkg.sv =====
package sbod_pkg;

  // Baseline store and sample counter
  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);

  // Field widths
  localparam int RANGE_IN_W = 16;
  localparam int THR_W      = 16;
  localparam int SLEN_W     = 11;
  localparam int DIST_W     = 13;

  // Clamped sample range
  localparam int RANGE_W      = 12;
  localparam int RANGE_MAX_MM = 4000;
  localparam int RANGE_MIN_MM = 50;
  localparam int START_MIN_MM = 2500;

  // Cosine table: Q1.COS_FRAC_BITS magnitude plus a sign bit on top
  localparam int COS_FRAC_BITS = 14;
  localparam int COS_MAG_W     = COS_FRAC_BITS + 1;
  localparam int PROD_W        = RANGE_W + COS_MAG_W;

  // Request kinds
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // Register index (paddr[2])
  typedef enum logic {
    REG_THRESHOLD   = 1'b0,
    REG_SCAN_LENGTH = 1'b1
  } reg_idx_t;

  typedef logic [COS_MAG_W:0] cos_entry_t;
  typedef cos_entry_t [MAX_SAMPLES-1:0] cos_rom_t;

  // Cosine of k * 0.352 deg, 13-term Taylor series in Q28 with each term
  // truncated, clamped at zero, rounded half up to COS_FRAC_BITS.
  function automatic cos_entry_t cos_entry(input int k);
    logic [63:0]        m;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    logic               neg;
    m   = (64'(k) * 64'd352) % 64'd360000;
    neg = 1'b0;
    if (m > 64'd180000) begin
      m = 64'd360000 - m;
    end
    if (m > 64'd90000) begin
      m   = 64'd180000 - m;
      neg = 1'b1;
    end
    x    = ((m * 64'd314159) << 28) / 64'd18000000000;
    x2   = (x * x) >> 28;
    sum  = 64'sd1 <<< 28;
    term = 64'd1 << 28;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    q = ($unsigned(sum) + (64'd1 << (27 - COS_FRAC_BITS))) >> (28 - COS_FRAC_BITS);
    return {neg, q[COS_MAG_W-1:0]};
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      rom[k] = cos_entry(k);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== hdl/sbod_ram.sv =====
module sbod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/scan_baseline_obstacle_distance.sv =====
// Channel   | Dir | Handshake        | Payload
// ----------+-----+------------------+---------------------------------------------
// s_*       | in  | s_tvalid/tready  | tdata: entry_index, range_mm; tuser: cmd,
//           |     |                  | sample_valid; tlast: last_sample
// m_*       | out | m_tvalid/tready  | tdata: nearest_distance_mm, obstacle_seen
// APB       | in  | psel/penable     | reg 0 threshold (0x0), reg 1 scan length (0x4)
//
// One request per cycle while s_tready is high. A scan sample passes three
// stages: baseline RAM and cosine ROM read, threshold test with the 12x15
// multiply, minimum update. A scan result is registered into m_tdata when its
// last sample leaves the final stage. After reset a clearing pass zeroes the
// baseline RAM, one entry a cycle, through all 1024 entries; s_tready stays low
// meanwhile, APB writes still land. Outside that pass, s_tready drops only while
// a result waits on m_tready and another last sample sits in the final stage.
module scan_baseline_obstacle_distance (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [9:0] entry_index, [25:10] range_mm, [31:26] zero
  input  logic [1:0]  s_tuser,   // [0] cmd, [1] sample_valid
  input  logic        s_tlast,   // last_sample
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [12:0] nearest_distance_mm, [13] obstacle_seen, [15:14] zero
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = sbod_pkg::IDX_W;
  localparam int RW     = sbod_pkg::RANGE_W;
  localparam int DW     = sbod_pkg::DIST_W;
  localparam int CMW    = sbod_pkg::COS_MAG_W;
  localparam int PW     = sbod_pkg::PROD_W;
  localparam int RIW    = sbod_pkg::RANGE_IN_W;

  // config registers
  logic [sbod_pkg::THR_W-1:0]  threshold;
  logic [sbod_pkg::SLEN_W-1:0] scan_length;

  // clearing pass
  logic [IDX_W:0] clear_cnt;
  logic           clearing;

  // request fields
  logic [IDX_W-1:0]  in_index;
  logic [RIW-1:0]    in_range;
  sbod_pkg::cmd_t    in_cmd;
  logic              in_valid_rd;

  // stage 0
  logic              advance;
  logic              s_accept;
  logic              sample_accept;
  logic              load_accept;
  logic [IDX_W-1:0]  sample_position;
  logic [IDX_W-1:0]  centre;
  logic [IDX_W-1:0]  offset;
  logic [RW-1:0]     clamped;

  // stage 1
  logic              st1_valid;
  logic              st1_last;
  logic [RW-1:0]     st1_s;
  sbod_pkg::cos_entry_t st1_cos;
  logic [RIW-1:0]    base;
  logic [RIW:0]      diff;
  logic              cand;

  // stage 2
  logic              st2_valid;
  logic              st2_last;
  logic              st2_cand;
  logic              st2_neg;
  logic [PW-1:0]     st2_prod;
  logic [DW-1:0]     mag;
  logic signed [DW-1:0] proj_mm;
  logic signed [DW-1:0] min_next;
  logic              any_next;

  // running state
  logic signed [DW-1:0] running_minimum;
  logic              any_obstacle;

  // result register
  logic signed [DW-1:0] out_dist;
  logic              out_seen;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RIW-1:0]    ram_wdata;

  logic              cfg_write;

  // ---------------- config port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (sbod_pkg::reg_idx_t'(paddr[2]))
      sbod_pkg::REG_THRESHOLD:   prdata = {16'd0, threshold};
      sbod_pkg::REG_SCAN_LENGTH: prdata = {21'd0, scan_length};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= sbod_pkg::THR_W'(80);
      scan_length <= sbod_pkg::SLEN_W'(512);
    end else if (cfg_write) begin
      unique case (sbod_pkg::reg_idx_t'(paddr[2]))
        sbod_pkg::REG_THRESHOLD:   threshold   <= pwdata[sbod_pkg::THR_W-1:0];
        sbod_pkg::REG_SCAN_LENGTH: scan_length <= pwdata[sbod_pkg::SLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: accept, RAM/ROM read ----------------
  assign in_index    = s_tdata[IDX_W-1:0];
  assign in_range    = s_tdata[10 +: RIW];
  assign in_cmd      = sbod_pkg::cmd_t'(s_tuser[0]);
  assign in_valid_rd = s_tuser[1];

  assign clearing = !clear_cnt[IDX_W];

  // pipeline only blocks when a finished scan result cannot be handed over
  assign advance       = !(st2_valid && st2_last && m_tvalid && !m_tready);
  assign s_tready      = !clearing && advance;
  assign s_accept      = s_tvalid && s_tready;
  assign sample_accept = s_accept && (in_cmd == sbod_pkg::CMD_SAMPLE);
  assign load_accept   = s_accept && (in_cmd == sbod_pkg::CMD_LOAD);

  assign centre = scan_length[IDX_W:1];
  assign offset = (sample_position >= centre) ? sample_position - centre
                                              : centre - sample_position;

  always_comb begin
    if (!in_valid_rd || in_range > RIW'(sbod_pkg::RANGE_MAX_MM)
        || in_range < RIW'(sbod_pkg::RANGE_MIN_MM)) begin
      clamped = RW'(sbod_pkg::RANGE_MAX_MM);
    end else begin
      clamped = in_range[RW-1:0];
    end
  end

  assign ram_we    = clearing || load_accept;
  assign ram_waddr = clearing ? clear_cnt[IDX_W-1:0] : in_index;
  assign ram_wdata = clearing ? '0 : in_range;

  sbod_ram #(
    .WIDTH (RIW),
    .DEPTH (sbod_pkg::MAX_SAMPLES)
  ) u_baseline (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (sample_accept),
    .raddr (sample_position),
    .rdata (base)
  );

  // ---------------- stage 1: baseline test, multiply ----------------
  assign diff = {1'b0, base} - (RIW+1)'(st1_s);
  assign cand = !diff[RIW] && (diff[RIW-1:0] > threshold);

  // ---------------- stage 2: minimum update ----------------
  assign mag     = st2_prod[sbod_pkg::COS_FRAC_BITS +: DW];
  assign proj_mm = st2_neg ? -$signed(mag) : $signed(mag);

  always_comb begin
    min_next = running_minimum;
    if (st2_cand && proj_mm < running_minimum) begin
      min_next = proj_mm;
    end
    any_next = any_obstacle || st2_cand;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt       <= '0;
      sample_position <= '0;
      st1_valid       <= 1'b0;
      st2_valid       <= 1'b0;
      running_minimum <= DW'(sbod_pkg::START_MIN_MM);
      any_obstacle    <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (sample_accept) begin
        sample_position <= s_tlast ? '0 : sample_position + 1'b1;
      end
      if (advance) begin
        st1_valid <= sample_accept;
        st2_valid <= st1_valid;
        if (st2_valid) begin
          if (st2_last) begin
            running_minimum <= DW'(sbod_pkg::START_MIN_MM);
            any_obstacle    <= 1'b0;
          end else begin
            running_minimum <= min_next;
            any_obstacle    <= any_next;
          end
        end
      end
      if (advance && st2_valid && st2_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (sample_accept) begin
      st1_cos <= sbod_pkg::COS_ROM[offset];
    end
    if (advance) begin
      st1_s    <= clamped;
      st1_last <= s_tlast;
      st2_last <= st1_last;
      st2_cand <= cand;
      st2_neg  <= st1_cos[CMW];
      st2_prod <= PW'(st1_s) * PW'(st1_cos[CMW-1:0])
                  + PW'(1 << (sbod_pkg::COS_FRAC_BITS - 1));
      if (st2_valid && st2_last) begin
        out_dist <= min_next;
        out_seen <= any_next;
      end
    end
  end

  assign m_tdata = {2'b00, out_seen, out_dist};

  // ---------------- checks ----------------
  assert property (@(posedge clk) disable iff (rst)
    running_minimum <= DW'(sbod_pkg::START_MIN_MM))
    else $error("running minimum above start value");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[13] |-> out_dist == DW'(sbod_pkg::START_MIN_MM))
    else $error("result without obstacle carries a changed minimum");

  assert property (@(posedge clk) disable iff (rst)
    st2_valid && st2_last && m_tvalid && !m_tready |=> st2_valid && st2_last)
    else $error("blocked last sample lost from final stage");

  assert property (@(posedge clk) disable iff (rst)
    sample_accept && s_tlast |=> sample_position == '0)
    else $error("sample counter not rewound after last sample");

  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_accept && ram_we)
    else $error("request taken during clearing pass");

endmodule
